### hw/rtl/hta_pkg.sv
package hta_pkg;

	localparam int ENTRIES_DEFAULT      = 64;
	localparam int PAYLOAD_BITS_DEFAULT = 32;

	// Width of the active slot count register and its reset value.
	localparam int           ACTIVE_W     = 7;
	localparam int           ACTIVE_MAX   = (2 ** ACTIVE_W) - 1;
	localparam int           LIM_CMP_W    = ACTIVE_W + 1;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

	// Handle sequence constants.
	localparam logic [31:0] FULL_MARK = 32'hFFFF_FFFF;
	localparam logic [31:0] LAST_SEQ  = 32'hFFFF_FFFE;
	localparam logic [31:0] FIRST_SEQ = 32'h0000_0001;

	// Operation codes on the mode field.
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	// Status codes on the result.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	// Class of an item as decided by the front end.
	typedef enum logic [2:0] {
		OP_INSERT,
		OP_LOOKUP,
		OP_DELETE,
		OP_FULL,
		OP_INVALID
	} op_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] handle;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [31:0] payload_out;
	} out_item_t;

	// Queue entry handed from the front end to the back end.
	typedef struct packed {
		op_t                 op;
		logic [ACTIVE_W-1:0] lim;
		logic [31:0]         handle;
		logic [31:0]         payload;
	} cmd_t;

endpackage

### hw/rtl/handle_table_allocator.sv
// Handle table allocator: a table of slots, each holding a sequence handle and a
// payload word. An item is accepted on a rising edge with start high and busy low.
// Mode insert claims the lowest free slot, issues the next handle and stores the
// payload; lookup returns the payload of the slot holding the handle; delete frees it.
// Every item gives exactly one result, shown for a single cycle with done high; the
// receiver cannot hold it off, so results never wait inside the block.
// The active slot count is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high. The user must write it only while idle; the block does not enforce it.
// The front end classifies items into a two-entry queue, so start is taken while the
// back end is still working; busy is high only when that queue is full.
// The back end scans the slots one per cycle through a memory with a registered read.
// An item that hits at slot k ends its scan there; a full table or a miss scans all
// active slots. Items that need no scan (a lookup or delete of handle zero, unused
// mode, no active slots) are answered from the idle state. With items queued, the
// back end starts the next one in the cycle after a result is chosen.
// Reset clears all slots to free at once through per-slot occupied flags, sets the
// next handle to 1 and the active count to 64; no clearing pass is needed.
module handle_table_allocator #(
	parameter int ENTRIES      = hta_pkg::ENTRIES_DEFAULT,
	parameter int PAYLOAD_BITS = hta_pkg::PAYLOAD_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  hta_pkg::in_item_t            cmd,
	output logic                         done,
	output hta_pkg::out_item_t           rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hta_pkg::ACTIVE_W-1:0] cfg_data
);

	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;
	hta_pkg::cmd_t entry;
	hta_pkg::cmd_t head;

	// The front end decides the class of each item and the scan limit.
	hta_front #(
		.ENTRIES (ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.full      (full),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.entry     (entry)
	);

	// A short queue decouples accepting items from carrying them out.
	hta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (full)
	);

	// The back end owns the slot storage and produces the results.
	hta_back #(
		.ENTRIES      (ENTRIES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.rsp        (rsp)
	);

	assign busy = full;

	// An accepted item is always waiting in the queue on the next cycle.
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> head_valid)
		else $error("accepted item not in queue");

	// Results can only follow an item that was waiting in the queue.
	a_done_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(head_valid))
		else $error("result without a queued item");

	// A successful operation never reports the free handle.
	a_ok_handle: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == hta_pkg::STATUS_OK |-> rsp.handle_out != '0)
		else $error("ok result carries handle zero");

	// A full table always answers with the full marker and no payload.
	a_full_mark: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == hta_pkg::STATUS_FULL |->
			rsp.handle_out == hta_pkg::FULL_MARK && rsp.payload_out == '0)
		else $error("full result malformed");

endmodule

### hw/rtl/hta_front.sv
module hta_front #(
	parameter int ENTRIES = hta_pkg::ENTRIES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          full,
	input  hta_pkg::in_item_t             cmd,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hta_pkg::ACTIVE_W-1:0]  cfg_data,
	output logic                          push,
	output hta_pkg::cmd_t                 entry
);

	localparam int SLOTS = (ENTRIES < hta_pkg::ACTIVE_MAX) ? ENTRIES : hta_pkg::ACTIVE_MAX;

	logic [hta_pkg::ACTIVE_W-1:0] active_q;
	logic [hta_pkg::ACTIVE_W-1:0] lim;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= hta_pkg::ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Counts above the table size behave as the table size.
	always_comb begin
		if (int'(active_q) > SLOTS) begin
			lim = hta_pkg::ACTIVE_W'(SLOTS);
		end else begin
			lim = active_q;
		end
	end

	// Items that need no scan are resolved here so the back end answers them at once.
	always_comb begin
		entry.lim     = lim;
		entry.handle  = cmd.handle;
		entry.payload = cmd.payload;
		case (cmd.mode)
			hta_pkg::MODE_INSERT: begin
				entry.op = (lim == '0) ? hta_pkg::OP_FULL : hta_pkg::OP_INSERT;
			end
			hta_pkg::MODE_LOOKUP: begin
				entry.op = (lim == '0 || cmd.handle == '0) ? hta_pkg::OP_INVALID
				                                          : hta_pkg::OP_LOOKUP;
			end
			hta_pkg::MODE_DELETE: begin
				entry.op = (lim == '0 || cmd.handle == '0) ? hta_pkg::OP_INVALID
				                                          : hta_pkg::OP_DELETE;
			end
			default: begin
				entry.op = hta_pkg::OP_INVALID;
			end
		endcase
	end

	assign push = start && !full;

endmodule

### hw/rtl/hta_queue.sv
module hta_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hta_pkg::cmd_t wr_entry,
	input  logic          pop,
	output logic          head_valid,
	output hta_pkg::cmd_t head,
	output logic          full
);

	hta_pkg::cmd_t slots_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/hta_back.sv
module hta_back #(
	parameter int ENTRIES      = hta_pkg::ENTRIES_DEFAULT,
	parameter int PAYLOAD_BITS = hta_pkg::PAYLOAD_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  hta_pkg::cmd_t      head,
	output logic               pop,
	output logic               done,
	output hta_pkg::out_item_t rsp
);

	localparam int SLOTS = (ENTRIES < hta_pkg::ACTIVE_MAX) ? ENTRIES : hta_pkg::ACTIVE_MAX;
	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int LW    = hta_pkg::LIM_CMP_W;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_SCAN = 2'b10
	} bstate_t;

	logic [31:0]           hmem [SLOTS];
	logic [PAYLOAD_BITS-1:0] pmem [SLOTS];
	logic [SLOTS-1:0]      occ_q;

	bstate_t               state_q;
	logic [CW-1:0]         idx_q;
	logic                  chk_s1;
	logic [IW-1:0]         idx_s1;
	logic [31:0]           hrd_s1;
	logic [PAYLOAD_BITS-1:0] prd_s1;
	logic [31:0]           next_q;
	logic                  done_q;
	hta_pkg::out_item_t    rsp_q;
	hta_pkg::out_item_t    rsp_d;

	logic is_ins;
	logic occ_bit;
	logic hit;
	logic last;
	logic finish;
	logic issue;
	logic quick;
	logic wr;

	assign is_ins  = (head.op == hta_pkg::OP_INSERT);
	assign occ_bit = occ_q[idx_s1];
	// Insert looks for a free slot, lookup and delete for an occupied slot with the key.
	assign hit     = is_ins ? !occ_bit : (occ_bit && hrd_s1 == head.handle);
	assign last    = (LW'(idx_s1) == (LW'(head.lim) - LW'(1)));
	assign finish  = (state_q == B_SCAN) && chk_s1 && (hit || last);
	assign issue   = (state_q == B_SCAN) && !finish && (LW'(idx_q) < LW'(head.lim));
	assign quick   = (state_q == B_IDLE) && head_valid &&
	                 (head.op == hta_pkg::OP_FULL || head.op == hta_pkg::OP_INVALID);
	assign pop     = quick || finish;
	assign wr      = finish && is_ins && hit;

	always_comb begin
		rsp_d.status      = hta_pkg::STATUS_INVALID;
		rsp_d.handle_out  = head.handle;
		rsp_d.payload_out = '0;
		if (quick) begin
			if (head.op == hta_pkg::OP_FULL) begin
				rsp_d.status     = hta_pkg::STATUS_FULL;
				rsp_d.handle_out = hta_pkg::FULL_MARK;
			end
		end else if (is_ins) begin
			if (hit) begin
				rsp_d.status     = hta_pkg::STATUS_OK;
				rsp_d.handle_out = next_q;
			end else begin
				rsp_d.status     = hta_pkg::STATUS_FULL;
				rsp_d.handle_out = hta_pkg::FULL_MARK;
			end
		end else if (hit) begin
			rsp_d.status      = hta_pkg::STATUS_OK;
			rsp_d.payload_out = 32'(prd_s1);
		end
	end

	// Slot storage: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (issue) begin
			hrd_s1 <= hmem[idx_q[IW-1:0]];
			prd_s1 <= pmem[idx_q[IW-1:0]];
		end
		if (wr) begin
			hmem[idx_s1] <= next_q;
			pmem[idx_s1] <= PAYLOAD_BITS'(head.payload);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
		if (pop) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			chk_s1  <= 1'b0;
			occ_q   <= '0;
			next_q  <= hta_pkg::FIRST_SEQ;
			done_q  <= 1'b0;
		end else begin
			done_q <= pop;
			case (state_q)
				B_IDLE: begin
					chk_s1 <= 1'b0;
					idx_q  <= '0;
					if (head_valid && !quick) begin
						state_q <= B_SCAN;
					end
				end
				B_SCAN: begin
					chk_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (finish) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (wr) begin
				occ_q[idx_s1] <= 1'b1;
				next_q <= (next_q >= hta_pkg::LAST_SEQ || next_q == '0) ? hta_pkg::FIRST_SEQ
				                                                         : next_q + 32'd1;
			end
			if (finish && head.op == hta_pkg::OP_DELETE && hit) begin
				occ_q[idx_s1] <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### bench/handle_table_allocator_test.sv
module handle_table_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock period, how long the bench lets the block settle before a write to the
	// active count, and how many cycles without any handshake end the run.
	localparam int CLK_PERIOD    = 10;
	localparam int SLOTS         = hta_pkg::ENTRIES_DEFAULT;
	localparam int SETTLE_CYCLES = SLOTS + 8;
	localparam int QUIET_LIMIT   = 1000;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASE_ITEMS   = 57;

	// The mode field has one code that the block does not use.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// A directed row whose result is taken from the table model carries this as its result.
	localparam hta_pkg::out_item_t BY_MODEL = '0;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	hta_pkg::in_item_t            cmd;
	logic                         done;
	hta_pkg::out_item_t           rsp;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [hta_pkg::ACTIVE_W-1:0] cfg_data;

	handle_table_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// The bench keeps its own copy of the table: one handle and one payload per slot,
	// the next handle to be issued and the active count as last written.
	logic [31:0]                  tbl_handle [SLOTS];
	logic [31:0]                  tbl_payload [SLOTS];
	logic [31:0]                  next_seq;
	logic [hta_pkg::ACTIVE_W-1:0] tbl_active;

	// Results owed by the block, oldest first.
	hta_pkg::out_item_t awaited_rsps [$];
	hta_pkg::out_item_t want;
	int                 mismatches;
	int                 quiet_cycles;
	int                 insert_pct;
	int                 idle_pct;

	// A directed item, and its result when that result is obvious by inspection.
	typedef struct packed {
		hta_pkg::in_item_t  item;
		logic               typed;
		hta_pkg::out_item_t result;
	} dir_row_t;

	// Directed items, run right after reset with all 64 slots active. Handles are
	// issued from 1 upward, so the first rows can state their results outright.
	dir_row_t directed_rows [19] = '{
		// Payload extremes on insert: the first two handles are 1 and 2.
		'{'{hta_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd1, 32'h0000_0000}},
		'{'{hta_pkg::MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd2, 32'h0000_0000}},
		'{'{hta_pkg::MODE_LOOKUP, 32'd1, 32'h0000_0000}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd1, 32'h0000_0000}},
		'{'{hta_pkg::MODE_LOOKUP, 32'd2, 32'h0000_0000}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd2, 32'hFFFF_FFFF}},
		// Handle zero never matches, even though free slots in the bench's table hold zero.
		'{'{hta_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'h0000_0000, 32'h0}},
		'{'{hta_pkg::MODE_DELETE, 32'h0000_0000, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'h0000_0000, 32'h0}},
		// Handles that were never issued.
		'{'{hta_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'hFFFF_FFFF, 32'h0}},
		'{'{hta_pkg::MODE_DELETE, 32'hFFFF_FFFE, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'hFFFF_FFFE, 32'h0}},
		// The unused mode echoes the handle and changes nothing.
		'{'{MODE_UNUSED, 32'h1234_5678, 32'hDEAD_BEEF}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'h1234_5678, 32'h0}},
		'{'{MODE_UNUSED, 32'h0000_0000, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'h0000_0000, 32'h0}},
		// Delete frees slot 0, after which handle 1 is gone.
		'{'{hta_pkg::MODE_DELETE, 32'd1, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd1, 32'h0000_0000}},
		'{'{hta_pkg::MODE_LOOKUP, 32'd1, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_INVALID, 32'd1, 32'h0000_0000}},
		// The handle field is ignored on insert; slot 0 is reused with handle 3.
		'{'{hta_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd3, 32'h0000_0000}},
		'{'{hta_pkg::MODE_DELETE, 32'd2, 32'h0}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd2, 32'hFFFF_FFFF}},
		'{'{hta_pkg::MODE_INSERT, 32'h0000_0000, 32'h5A5A_5A5A}, 1'b1,
			'{hta_pkg::STATUS_OK, 32'd4, 32'h0000_0000}},
		'{'{hta_pkg::MODE_LOOKUP, 32'd3, 32'h0}, 1'b0, BY_MODEL},
		'{'{hta_pkg::MODE_LOOKUP, 32'd4, 32'h0}, 1'b0, BY_MODEL},
		'{'{hta_pkg::MODE_DELETE, 32'd3, 32'h0}, 1'b0, BY_MODEL},
		'{'{hta_pkg::MODE_INSERT, 32'h0000_0000, 32'h8000_0001}, 1'b0, BY_MODEL}
	};

	// Settings for the random phases: the active count written before the phase, how
	// often the sender idles, and how many items are inserts. The count walks through
	// the legal extremes, zero and the largest value the register holds. The insert
	// heavy phase with all slots active drives the table to full with a 64-slot scan.
	logic [hta_pkg::ACTIVE_W-1:0] phase_active [7] =
		'{7'd64, 7'd4, 7'd1, 7'd0, 7'd127, 7'd23, 7'd64};
	int                           phase_idle   [7] = '{0, 64, 0, 28, 64, 0, 28};
	int                           phase_insert [7] = '{45, 35, 35, 35, 70, 40, 35};

	// Number of slots that the block scans under the current active count.
	function automatic int scan_span();
		return (tbl_active > SLOTS) ? SLOTS : int'(tbl_active);
	endfunction

	// Carries out one item on the bench's copy of the table and returns its result.
	function automatic hta_pkg::out_item_t apply_table_op(hta_pkg::in_item_t it);
		hta_pkg::out_item_t r;
		int                 span;
		int                 slot;
		span          = scan_span();
		slot          = -1;
		r.status      = hta_pkg::STATUS_INVALID;
		r.handle_out  = it.handle;
		r.payload_out = '0;
		case (it.mode)
		hta_pkg::MODE_INSERT: begin
			// Scan downward so that the lowest free slot wins.
			for (int i = span - 1; i >= 0; i--)
				if (tbl_handle[i] == '0)
					slot = i;
			if (slot >= 0) begin
				tbl_handle[slot]  = next_seq;
				tbl_payload[slot] = it.payload;
				r.status          = hta_pkg::STATUS_OK;
				r.handle_out      = next_seq;
				next_seq = (next_seq >= hta_pkg::LAST_SEQ || next_seq == '0) ?
					hta_pkg::FIRST_SEQ : next_seq + 32'd1;
			end else begin
				r.status     = hta_pkg::STATUS_FULL;
				r.handle_out = hta_pkg::FULL_MARK;
			end
		end
		hta_pkg::MODE_LOOKUP, hta_pkg::MODE_DELETE: begin
			if (it.handle != '0)
				for (int i = span - 1; i >= 0; i--)
					if (tbl_handle[i] == it.handle)
						slot = i;
			if (slot >= 0) begin
				r.status      = hta_pkg::STATUS_OK;
				r.payload_out = tbl_payload[slot];
				if (it.mode == hta_pkg::MODE_DELETE)
					tbl_handle[slot] = '0;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// Picks a handle that some slot holds, mostly among the scanned slots and sometimes
	// from slots beyond the active count; falls back to a random word if none is live.
	function automatic logic [31:0] pick_live();
		int idx [$];
		int span;
		span = ($urandom_range(0, 99) < 80) ? scan_span() : SLOTS;
		for (int i = 0; i < span; i++)
			if (tbl_handle[i] != '0)
				idx.push_back(i);
		if (idx.size() == 0)
			return $urandom();
		return tbl_handle[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction

	// Random item. Most lookups and deletes name a live handle so that hits and frees
	// happen often; the rest are misses, handle zero and the unused mode.
	function automatic hta_pkg::in_item_t random_item();
		hta_pkg::in_item_t it;
		int                roll;
		it.mode    = ($urandom_range(0, 1) == 0) ? hta_pkg::MODE_LOOKUP : hta_pkg::MODE_DELETE;
		it.handle  = $urandom();
		it.payload = $urandom();
		roll       = $urandom_range(0, 99);
		if (roll < insert_pct) begin
			it.mode = hta_pkg::MODE_INSERT;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				it.handle = pick_live();
			else if (roll < 87)
				it.handle = it.handle;
			else if (roll < 94)
				it.handle = '0;
			else
				it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	// Offers one item and holds it until the block takes it. The expected result is
	// queued at the edge that accepts the item; a directed row may supply it directly.
	task automatic send_item(hta_pkg::in_item_t it, logic typed,
			hta_pkg::out_item_t typed_rsp);
		hta_pkg::out_item_t predicted;
		start <= 1'b1;
		cmd   <= it;
		do
			@(posedge clk);
		while (busy);
		predicted = apply_table_op(it);
		awaited_rsps.push_back(typed ? typed_rsp : predicted);
	endtask

	// Stops offering items and waits until every owed result has come back.
	task automatic wait_all_answered();
		start <= 1'b0;
		while (awaited_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Writes the active count. Only called once the block is idle.
	task automatic write_active(logic [hta_pkg::ACTIVE_W-1:0] count);
		cfg_data  <= count;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		tbl_active  = count;
	endtask

	// Every result is checked against the oldest expectation, field by field. The block
	// cannot be held off, so a result is taken in the very cycle that done is high.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: status %0d handle %h payload %h",
						rsp.status, rsp.handle_out, rsp.payload_out);
			end else begin
				want = awaited_rsps.pop_front();
				if (rsp.status !== want.status || rsp.handle_out !== want.handle_out ||
						rsp.payload_out !== want.payload_out) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("wrong result: status %0d/%0d handle %h/%h payload %h/%h %s",
							want.status, rsp.status, want.handle_out, rsp.handle_out,
							want.payload_out, rsp.payload_out, "(expected/actual)");
				end
			end
		end
	end

	// Watchdog: a long stretch with no accepted item, no result and no register write
	// means the block has hung. The longest legal quiet stretch is the settle pause.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// All inputs are known from time zero; reset is held low before the first item.
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		mismatches   = 0;
		quiet_cycles = 0;
		insert_pct   = 0;
		idle_pct     = 0;
		next_seq     = hta_pkg::FIRST_SEQ;
		tbl_active   = hta_pkg::ACTIVE_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_handle[i]  = '0;
			tbl_payload[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items back to back, under the active count left by reset.
		foreach (directed_rows[k])
			send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].result);

		// Random phases. Each begins from an idle block, since the active count may
		// only change while nothing is in flight.
		for (int p = 0; p < 7; p++) begin
			wait_all_answered();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_active(phase_active[p]);
			insert_pct = phase_insert[p];
			idle_pct   = phase_idle[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_item(), 1'b0, '0);
				// Now and then let the block run completely dry mid-phase.
				if ($urandom_range(0, 49) == 0)
					wait_all_answered();
				// Idle cycles come one at a time, so gaps of every length fall on every
				// phase of the scan.
				while ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
			end
		end

		wait_all_answered();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += awaited_rsps.size();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
